FILE: sv/mtoc_pkg.sv
// Package for the map-to-odometry pose correction block.
// Holds sizing constants, codes, the CORDIC arctangent table and the
// command and status types shared by the controller and the datapath.
`default_nettype none

package mtoc_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int FRAC_BITS    = 16;

    localparam int CNT_W = 5;
    localparam int CS_W  = FRAC_BITS + 3;
    localparam int RS_SH = 30 - FRAC_BITS;
    localparam int CR_W  = 36;
    localparam int CZ_W  = 34;
    localparam int P_W   = CS_W + 32;
    localparam int ACC_W = P_W + 2;

    localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(CORDIC_STEPS - 1);
    localparam logic [CNT_W-1:0] MAC_LAST  = CNT_W'(3);

    typedef enum logic [1:0] {
        KIND_MAP  = 2'd0,
        KIND_ODO  = 2'd1,
        KIND_TICK = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        PH_MAP  = 2'd0,
        PH_INV  = 2'd1,
        PH_CMP  = 2'd2,
        PH_HALF = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        CFG_OFFSET_X   = 2'd0,
        CFG_OFFSET_Y   = 2'd1,
        CFG_OFFSET_YAW = 2'd2,
        CFG_TOLERANCE  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic             capture;
        logic             qmul;
        logic             vinit;
        logic             vstep;
        logic             vstore;
        logic             rinit;
        logic             rstep;
        logic             rdone;
        logic             mac;
        logic             mdone;
        logic             finish;
        t_phase           ph;
        logic [CNT_W-1:0] cnt;
    } t_cmd;

    typedef struct packed {
        logic map_seen;
        logic odo_seen;
        logic out_free;
    } t_sts;

    function automatic logic [31:0] atan_val(input logic [CNT_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: sv/mtoc_ctrl.sv
// Controller state machine for the pose correction block.
// Sequences the multiply, CORDIC and accumulate steps; uses mtoc_pkg.
`default_nettype none

module mtoc_ctrl
    import mtoc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [1:0] i_kind,
    output logic            o_ready,
    input  wire t_sts       i_sts,
    output t_cmd            o_cmd
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_QMUL   = 11'b000_0000_0010,
        S_VINIT  = 11'b000_0000_0100,
        S_VEC    = 11'b000_0000_1000,
        S_VSTORE = 11'b000_0001_0000,
        S_RINIT  = 11'b000_0010_0000,
        S_ROT    = 11'b000_0100_0000,
        S_RDONE  = 11'b000_1000_0000,
        S_MAC    = 11'b001_0000_0000,
        S_MDONE  = 11'b010_0000_0000,
        S_OUT    = 11'b100_0000_0000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_phase           r_ph, n_ph;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_ph    = r_ph;
        o_cmd   = '0;
        o_cmd.ph  = r_ph;
        o_cmd.cnt = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_valid;
                if (i_valid) begin
                    n_cnt = '0;
                    n_ph  = PH_MAP;
                    if (i_kind == KIND_MAP || i_kind == KIND_ODO) begin
                        n_state = S_QMUL;
                    end else if (i_kind == KIND_TICK && i_sts.map_seen && i_sts.odo_seen) begin
                        n_state = S_RINIT;
                    end
                end
            end
            S_QMUL: begin
                o_cmd.qmul = 1'b1;
                if (r_cnt == MAC_LAST) begin
                    n_cnt   = '0;
                    n_state = S_VINIT;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_VINIT: begin
                o_cmd.vinit = 1'b1;
                n_state     = S_VEC;
            end
            S_VEC: begin
                o_cmd.vstep = 1'b1;
                if (r_cnt == STEP_LAST) begin
                    n_cnt   = '0;
                    n_state = S_VSTORE;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_VSTORE: begin
                o_cmd.vstore = 1'b1;
                n_state      = S_IDLE;
            end
            S_RINIT: begin
                o_cmd.rinit = 1'b1;
                n_cnt       = '0;
                n_state     = S_ROT;
            end
            S_ROT: begin
                o_cmd.rstep = 1'b1;
                if (r_cnt == STEP_LAST) begin
                    n_cnt   = '0;
                    n_state = S_RDONE;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_RDONE: begin
                o_cmd.rdone = 1'b1;
                n_cnt       = '0;
                if (r_ph == PH_HALF) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_MAC;
                end
            end
            S_MAC: begin
                o_cmd.mac = 1'b1;
                if (r_cnt == MAC_LAST) begin
                    n_cnt   = '0;
                    n_state = S_MDONE;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_MDONE: begin
                o_cmd.mdone = 1'b1;
                n_ph        = t_phase'(2'(r_ph + 2'd1));
                n_state     = S_RINIT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ph    <= PH_MAP;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ph    <= n_ph;
        end
    end

    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> i_sts.out_free)
        else $error("Result loaded while the output register was occupied.");

    a_tick_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_kind == KIND_TICK && i_sts.map_seen && i_sts.odo_seen)
        |=> (r_state == S_RINIT && r_ph == PH_MAP))
        else $error("Tick with both poses did not start the composition.");

    a_pose_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_kind == KIND_MAP || i_kind == KIND_ODO))
        |=> (r_state == S_QMUL && r_cnt == '0))
        else $error("Pose update did not start the quaternion products.");

    a_half_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RDONE && r_ph == PH_HALF) |=> (r_state == S_OUT))
        else $error("Half-angle rotation did not lead to the output state.");

endmodule

`default_nettype wire

FILE: sv/mtoc_dpath.sv
// Datapath for the pose correction block: pose and configuration registers,
// one shared CORDIC unit, one multiplier with accumulators, output register.
// Depends on mtoc_pkg.
`default_nettype none

module mtoc_dpath
    import mtoc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    output t_sts                    o_sts,
    input  wire logic [1:0]         i_kind,
    input  wire logic signed [31:0] i_pos_x,
    input  wire logic signed [31:0] i_pos_y,
    input  wire logic signed [15:0] i_quat_x,
    input  wire logic signed [15:0] i_quat_y,
    input  wire logic signed [15:0] i_quat_z,
    input  wire logic signed [15:0] i_quat_w,
    input  wire logic [30:0]        i_time_sec,
    input  wire logic [29:0]        i_time_nsec,
    input  wire logic               i_cfg_valid,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    input  wire logic               i_ready,
    output logic                    o_valid,
    output logic signed [31:0]      o_trans_x,
    output logic signed [31:0]      o_trans_y,
    output logic signed [15:0]      o_rot_z,
    output logic signed [15:0]      o_rot_w,
    output logic [30:0]             o_out_sec,
    output logic [29:0]             o_out_nsec
);

    localparam logic signed [CR_W-1:0]  GAIN_Q30 = CR_W'(652032874);
    localparam logic signed [CR_W-1:0]  C_HALF   = CR_W'(1) <<< (RS_SH - 1);
    localparam logic signed [CR_W-1:0]  H_HALF   = CR_W'(32768);
    localparam logic signed [19:0]      Q14_POS  = 20'sd16384;
    localparam logic signed [19:0]      Q14_NEG  = -20'sd16384;
    localparam logic signed [ACC_W-1:0] M_HALF   = ACC_W'(1) <<< (FRAC_BITS - 1);
    localparam logic [29:0]             TOL_MAX  = 30'd999999999;
    localparam logic [31:0]             NS_ONE   = 32'd1000000000;
    localparam logic [31:0]             NS_TWO   = 32'd2000000000;
    localparam logic [30:0]             SEC_MAX  = 31'h7fffffff;

    logic signed [31:0] r_off_x, r_off_y;
    logic signed [15:0] r_off_yaw;
    logic [29:0]        r_tol;
    logic               r_map_seen, r_odo_seen, r_ovalid;

    logic               r_in_odo;
    logic signed [31:0] r_in_x, r_in_y;
    logic signed [15:0] r_qx, r_qy, r_qz, r_qw;
    logic [30:0]        r_in_sec;
    logic [29:0]        r_in_nsec;

    logic signed [31:0] r_map_x, r_map_y, r_odo_x, r_odo_y;
    logic [15:0]        r_map_yaw, r_odo_yaw;
    logic [30:0]        r_map_sec;
    logic [29:0]        r_map_nsec;

    logic signed [CR_W-1:0]  r_cx, r_cy;
    logic signed [CZ_W-1:0]  r_cz;
    logic                    r_flip, r_vzero;
    logic signed [CS_W-1:0]  r_c, r_s;
    logic signed [15:0]      r_rz, r_rw;
    logic signed [ACC_W-1:0] r_acc1, r_acc2;
    logic signed [31:0]      r_mbx, r_mby, r_ix, r_iy, r_tx, r_ty;

    logic signed [31:0] r_o_tx, r_o_ty;
    logic signed [15:0] r_o_rz, r_o_rw;
    logic [30:0]        r_o_sec;
    logic [29:0]        r_o_nsec;

    logic [15:0]             mb_yaw, out_yaw;
    logic signed [16:0]      half_t;
    logic [31:0]             ang, ang_f, ang_r;
    logic signed [CS_W-1:0]  mul_a;
    logic signed [31:0]      mul_b, vec_a, vec_b, base_x, base_y;
    logic signed [P_W-1:0]   prod;
    logic signed [ACC_W-1:0] prod_e;
    logic signed [CR_W-1:0]  dx, dy, vx, vy, xf, yf, c_sum, s_sum, c_rnd, s_rnd;
    logic signed [CR_W-1:0]  hz_sum, hw_sum, hz_rnd, hw_rnd;
    logic signed [CZ_W-1:0]  at;
    logic                    sig_pos, inv_neg;
    logic [31:0]             zr;
    logic signed [ACC_W-1:0] m1_sum, m2_sum, m1_rnd, m2_rnd;
    logic signed [31:0]      res1, res2;
    logic signed [19:0]      hz20, hw20;
    logic signed [15:0]      hz_c, hw_c;
    logic [29:0]             tol;
    logic [31:0]             ns_sum, ns_out;
    logic [1:0]              carry;
    logic [31:0]             sec_sum;
    logic [30:0]             sec_out;

    assign mb_yaw  = r_map_yaw + r_off_yaw;
    assign out_yaw = mb_yaw - r_odo_yaw;
    assign half_t  = (out_yaw == 16'h8000) ? 17'sd32768 : 17'(signed'(out_yaw));

    always_comb begin
        case (i_cmd.ph)
            PH_MAP:  ang = {r_map_yaw, 16'd0};
            PH_INV:  ang = {r_odo_yaw, 16'd0};
            PH_CMP:  ang = {mb_yaw, 16'd0};
            default: ang = {half_t[16:0], 15'd0};
        endcase
        ang_f = ang + 32'h4000_0000;
        ang_r = ang_f[31] ? (ang + 32'h8000_0000) : ang;
    end

    always_comb begin
        case (i_cmd.ph)
            PH_MAP: begin
                vec_a  = r_off_x;
                vec_b  = r_off_y;
                base_x = r_map_x;
                base_y = r_map_y;
            end
            PH_INV: begin
                vec_a  = r_odo_x;
                vec_b  = r_odo_y;
                base_x = '0;
                base_y = '0;
            end
            default: begin
                vec_a  = r_ix;
                vec_b  = r_iy;
                base_x = r_mbx;
                base_y = r_mby;
            end
        endcase
    end

    always_comb begin
        if (i_cmd.qmul) begin
            case (i_cmd.cnt[1:0])
                2'd0: begin
                    mul_a = CS_W'(r_qw);
                    mul_b = 32'(r_qz);
                end
                2'd1: begin
                    mul_a = CS_W'(r_qx);
                    mul_b = 32'(r_qy);
                end
                2'd2: begin
                    mul_a = CS_W'(r_qy);
                    mul_b = 32'(r_qy);
                end
                default: begin
                    mul_a = CS_W'(r_qz);
                    mul_b = 32'(r_qz);
                end
            endcase
        end else begin
            mul_a = (i_cmd.cnt[0] ^ i_cmd.cnt[1]) ? r_s : r_c;
            mul_b = i_cmd.cnt[0] ? vec_b : vec_a;
        end
        prod    = mul_a * mul_b;
        prod_e  = {{(ACC_W - P_W){prod[P_W-1]}}, prod};
        inv_neg = i_cmd.mac && (i_cmd.ph == PH_INV);
    end

    always_comb begin
        vy = {r_acc1[CR_W-2:0], 1'b0};
        vx = (CR_W'(1) <<< 28) - {r_acc2[CR_W-2:0], 1'b0};
        dx = r_cy >>> i_cmd.cnt;
        dy = r_cx >>> i_cmd.cnt;
        at = {2'b00, atan_val(i_cmd.cnt)};
        sig_pos = i_cmd.vstep ? !(r_cy > 0) : !r_cz[CZ_W-1];
        zr = r_cz[31:0] + 32'h0000_8000;
    end

    always_comb begin
        xf     = r_flip ? -r_cx : r_cx;
        yf     = r_flip ? -r_cy : r_cy;
        c_sum  = xf + C_HALF;
        s_sum  = yf + C_HALF;
        c_rnd  = c_sum >>> RS_SH;
        s_rnd  = s_sum >>> RS_SH;
        hz_sum = yf + H_HALF;
        hw_sum = xf + H_HALF;
        hz_rnd = hz_sum >>> 16;
        hw_rnd = hw_sum >>> 16;
        hz20   = hz_rnd[19:0];
        hw20   = hw_rnd[19:0];
        hz_c   = (hz20 > Q14_POS) ? 16'sd16384 :
                 (hz20 < Q14_NEG) ? -16'sd16384 : hz20[15:0];
        hw_c   = (hw20 > Q14_POS) ? 16'sd16384 :
                 (hw20 < Q14_NEG) ? -16'sd16384 : hw20[15:0];
    end

    always_comb begin
        m1_sum = r_acc1 + M_HALF;
        m2_sum = r_acc2 + M_HALF;
        m1_rnd = m1_sum >>> FRAC_BITS;
        m2_rnd = m2_sum >>> FRAC_BITS;
        res1   = base_x + m1_rnd[31:0];
        res2   = base_y + m2_rnd[31:0];
    end

    always_comb begin
        tol    = (r_tol > TOL_MAX) ? TOL_MAX : r_tol;
        ns_sum = {2'b00, r_map_nsec} + {2'b00, tol};
        if (ns_sum >= NS_TWO) begin
            ns_out = ns_sum - NS_TWO;
            carry  = 2'd2;
        end else if (ns_sum >= NS_ONE) begin
            ns_out = ns_sum - NS_ONE;
            carry  = 2'd1;
        end else begin
            ns_out = ns_sum;
            carry  = 2'd0;
        end
        sec_sum = {1'b0, r_map_sec} + {30'd0, carry};
        sec_out = (sec_sum > {1'b0, SEC_MAX}) ? SEC_MAX : sec_sum[30:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_x    <= 32'sd17302;
            r_off_y    <= 32'sd1114;
            r_off_yaw  <= 16'sh8000;
            r_tol      <= 30'd20000000;
            r_map_seen <= 1'b0;
            r_odo_seen <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_OFFSET_X:   r_off_x   <= i_cfg_data;
                    CFG_OFFSET_Y:   r_off_y   <= i_cfg_data;
                    CFG_OFFSET_YAW: r_off_yaw <= i_cfg_data[15:0];
                    CFG_TOLERANCE:  r_tol     <= i_cfg_data[29:0];
                    default:        r_tol     <= r_tol;
                endcase
            end
            if (i_cmd.vstore) begin
                if (r_in_odo) begin
                    r_odo_seen <= 1'b1;
                end else begin
                    r_map_seen <= 1'b1;
                end
            end
            if (i_cmd.finish) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in_odo  <= (i_kind == KIND_ODO);
            r_in_x    <= i_pos_x;
            r_in_y    <= i_pos_y;
            r_qx      <= i_quat_x;
            r_qy      <= i_quat_y;
            r_qz      <= i_quat_z;
            r_qw      <= i_quat_w;
            r_in_sec  <= i_time_sec;
            r_in_nsec <= i_time_nsec;
        end
        if (i_cmd.qmul || i_cmd.mac) begin
            case (i_cmd.cnt[1:0])
                2'd0:    r_acc1 <= inv_neg ? -prod_e : prod_e;
                2'd1:    r_acc1 <= i_cmd.qmul ? (r_acc1 + prod_e) : (r_acc1 - prod_e);
                2'd2:    r_acc2 <= prod_e;
                default: r_acc2 <= inv_neg ? (r_acc2 - prod_e) : (r_acc2 + prod_e);
            endcase
        end
        if (i_cmd.vinit) begin
            r_vzero <= (vx == '0) && (vy == '0);
            if (vx < 0) begin
                r_cx <= -vx;
                r_cy <= -vy;
                r_cz <= CZ_W'(33'h0_8000_0000);
            end else begin
                r_cx <= vx;
                r_cy <= vy;
                r_cz <= '0;
            end
        end
        if (i_cmd.rinit) begin
            r_flip <= ang_f[31];
            r_cx   <= GAIN_Q30;
            r_cy   <= '0;
            r_cz   <= CZ_W'(signed'(ang_r));
        end
        if (i_cmd.vstep || i_cmd.rstep) begin
            if (sig_pos) begin
                r_cx <= r_cx - dx;
                r_cy <= r_cy + dy;
                r_cz <= r_cz - at;
            end else begin
                r_cx <= r_cx + dx;
                r_cy <= r_cy - dy;
                r_cz <= r_cz + at;
            end
        end
        if (i_cmd.vstore) begin
            if (r_in_odo) begin
                r_odo_x   <= r_in_x;
                r_odo_y   <= r_in_y;
                r_odo_yaw <= r_vzero ? 16'd0 : zr[31:16];
            end else begin
                r_map_x    <= r_in_x;
                r_map_y    <= r_in_y;
                r_map_yaw  <= r_vzero ? 16'd0 : zr[31:16];
                r_map_sec  <= r_in_sec;
                r_map_nsec <= r_in_nsec;
            end
        end
        if (i_cmd.rdone) begin
            if (i_cmd.ph == PH_HALF) begin
                r_rz <= hz_c;
                r_rw <= hw_c;
            end else begin
                r_c <= c_rnd[CS_W-1:0];
                r_s <= s_rnd[CS_W-1:0];
            end
        end
        if (i_cmd.mdone) begin
            case (i_cmd.ph)
                PH_MAP: begin
                    r_mbx <= res1;
                    r_mby <= res2;
                end
                PH_INV: begin
                    r_ix <= res1;
                    r_iy <= res2;
                end
                default: begin
                    r_tx <= res1;
                    r_ty <= res2;
                end
            endcase
        end
        if (i_cmd.finish) begin
            r_o_tx   <= r_tx;
            r_o_ty   <= r_ty;
            r_o_rz   <= r_rz;
            r_o_rw   <= r_rw;
            r_o_sec  <= sec_out;
            r_o_nsec <= ns_out[29:0];
        end
    end

    assign o_sts.map_seen = r_map_seen;
    assign o_sts.odo_seen = r_odo_seen;
    assign o_sts.out_free = !r_ovalid || i_ready;

    assign o_valid    = r_ovalid;
    assign o_trans_x  = r_o_tx;
    assign o_trans_y  = r_o_ty;
    assign o_rot_z    = r_o_rz;
    assign o_rot_w    = r_o_rw;
    assign o_out_sec  = r_o_sec;
    assign o_out_nsec = r_o_nsec;

endmodule

`default_nettype wire

FILE: sv/map_to_odom_pose_correction_top.sv
// Top level of the map-to-odometry pose correction block.
// Joins the controller (mtoc_ctrl) and the datapath (mtoc_dpath); uses mtoc_pkg.
//
// The block keeps the latest map pose and odometry pose as x, y and yaw and, on
// a publish tick once both are known, emits the map-to-odom translation, a
// half-angle quaternion and the map stamp plus the tolerance. Items are handled
// one at a time: a pose update runs four quaternion products on the shared
// multiplier, then 16 CORDIC vectoring steps, and a tick runs four 16-step CORDIC
// rotations and twelve products, all on the one CORDIC unit and the one
// multiplier. A tick that causes no result and an unknown kind are accepted
// without leaving the idle state. A finished result waits in the output register while the next
// transaction is taken. Configuration writes are taken in any cycle.
`default_nettype none

module map_to_odom_pose_correction_top
    import mtoc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [1:0]         i_kind,
    input  wire logic signed [31:0] i_pos_x,
    input  wire logic signed [31:0] i_pos_y,
    input  wire logic signed [15:0] i_quat_x,
    input  wire logic signed [15:0] i_quat_y,
    input  wire logic signed [15:0] i_quat_z,
    input  wire logic signed [15:0] i_quat_w,
    input  wire logic [30:0]        i_time_sec,
    input  wire logic [29:0]        i_time_nsec,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [31:0]      o_trans_x,
    output logic signed [31:0]      o_trans_y,
    output logic signed [15:0]      o_rot_z,
    output logic signed [15:0]      o_rot_w,
    output logic [30:0]             o_out_sec,
    output logic [29:0]             o_out_nsec
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    mtoc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_kind  (i_kind),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    mtoc_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_kind      (i_kind),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_quat_x    (i_quat_x),
        .i_quat_y    (i_quat_y),
        .i_quat_z    (i_quat_z),
        .i_quat_w    (i_quat_w),
        .i_time_sec  (i_time_sec),
        .i_time_nsec (i_time_nsec),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_ready     (i_ready),
        .o_valid     (o_valid),
        .o_trans_x   (o_trans_x),
        .o_trans_y   (o_trans_y),
        .o_rot_z     (o_rot_z),
        .o_rot_w     (o_rot_w),
        .o_out_sec   (o_out_sec),
        .o_out_nsec  (o_out_nsec)
    );

endmodule

`default_nettype wire

FILE: dv/map_to_odom_pose_correction_top_tb.sv
// Testbench for map_to_odom_pose_correction_top: random and directed pose,
// odometry and tick transactions checked against an in-bench fixed-point predictor.
// Depends on mtoc_pkg for the kind and register index codes and the sizing constants.
`timescale 1ns / 1ps

module map_to_odom_pose_correction_top_tb;
    import mtoc_pkg::*;

    localparam int STEPS = CORDIC_STEPS;
    localparam int FRACB = FRAC_BITS;
    localparam int WATCH_LIMIT = 200000;
    localparam int HOLD_CYCLES = 3000;

    typedef struct {
        logic [1:0]         kind;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
        logic signed [15:0] qw;
        logic [30:0]        sec;
        logic [29:0]        nsec;
    } pose_item_t;

    typedef struct {
        logic [31:0] tx;
        logic [31:0] ty;
        logic [15:0] rz;
        logic [15:0] rw;
        logic [30:0] sec;
        logic [29:0] nsec;
    } correction_t;

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_ready;
    logic [1:0] in_kind = 0;
    logic signed [31:0] in_px = 0, in_py = 0;
    logic signed [15:0] in_qx = 0, in_qy = 0, in_qz = 0, in_qw = 0;
    logic [30:0] in_sec = 0;
    logic [29:0] in_nsec = 0;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [1:0] cfg_index = 0;
    logic [31:0] cfg_data = 0;
    logic out_valid;
    logic out_ready = 0;
    logic signed [31:0] out_tx, out_ty;
    logic signed [15:0] out_rz, out_rw;
    logic [30:0] out_sec;
    logic [29:0] out_nsec;

    map_to_odom_pose_correction_top dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_ready(in_ready), .i_kind(in_kind),
        .i_pos_x(in_px), .i_pos_y(in_py),
        .i_quat_x(in_qx), .i_quat_y(in_qy), .i_quat_z(in_qz), .i_quat_w(in_qw),
        .i_time_sec(in_sec), .i_time_nsec(in_nsec),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_trans_x(out_tx), .o_trans_y(out_ty), .o_rot_z(out_rz), .o_rot_w(out_rw),
        .o_out_sec(out_sec), .o_out_nsec(out_nsec)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    longint unsigned atan_lut [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

    // Predictor state.
    logic [31:0] p_off_x, p_off_y, p_tol;
    logic [15:0] p_off_yaw;
    logic [31:0] p_map_x, p_map_y, p_odo_x, p_odo_y;
    logic [30:0] p_map_sec;
    logic [29:0] p_map_nsec;
    logic [15:0] p_map_yaw, p_odo_yaw;
    bit p_map_seen, p_odo_seen;

    pose_item_t  pending_items[$];
    correction_t expected_corr[$];
    int errors = 0;
    int results_seen = 0;
    int items_sent = 0;
    bit hold_req = 0;
    bit hold_done = 0;
    int hold_cycles = 0;
    int idle_cycles = 0;

    function automatic longint rnd_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    task automatic cordic_sincos(input logic [31:0] ang, output longint c, output longint s);
        bit flip;
        longint x, y, z, dx, dy;
        logic [31:0] a;
        a = ang;
        flip = ((a + 32'h4000_0000) & 32'h8000_0000) != 0;
        if (flip) a = a + 32'h8000_0000;
        z = longint'($signed(a));
        x = 652032874;
        y = 0;
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(atan_lut[i]);
            end else begin
                x += dx; y -= dy; z += longint'(atan_lut[i]);
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        c = x;
        s = y;
    endtask

    task automatic trig_q(input logic [15:0] yaw, output longint c, output longint s);
        longint cc, ss;
        cordic_sincos({yaw, 16'h0}, cc, ss);
        c = rnd_shift(cc, 30 - FRACB);
        s = rnd_shift(ss, 30 - FRACB);
    endtask

    function automatic logic [15:0] quat_yaw(longint qx, longint qy, longint qz, longint qw);
        longint x, y, dx, dy;
        logic [31:0] z;
        y = 2 * (qw * qz + qx * qy);
        x = (longint'(1) <<< 28) - 2 * (qy * qy + qz * qz);
        z = 0;
        if (x == 0 && y == 0) return 16'h0;
        if (x < 0) begin
            x = -x; y = -y; z = 32'h8000_0000;
        end
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z += 32'(atan_lut[i]);
            end else begin
                x -= dx; y += dy; z -= 32'(atan_lut[i]);
            end
        end
        z = z + 32'h8000;
        return z[31:16];
    endfunction

    function automatic longint clamp_unit(longint v);
        if (v > 16384) return 16384;
        if (v < -16384) return -16384;
        return v;
    endfunction

    task automatic predict_correction(input pose_item_t it);
        longint c, s, ox, oy, mbx, mby, ix, iy, t, hz, hw, tsum;
        logic [15:0] mb_yaw, yaw, y;
        logic [31:0] w;
        longint unsigned tol, ns, carry, sec;
        correction_t r;
        if (it.kind == KIND_MAP || it.kind == KIND_ODO) begin
            y = quat_yaw(it.qx, it.qy, it.qz, it.qw);
            if (it.kind == KIND_MAP) begin
                p_map_x = it.px; p_map_y = it.py; p_map_yaw = y;
                p_map_sec = it.sec; p_map_nsec = it.nsec; p_map_seen = 1;
            end else begin
                p_odo_x = it.px; p_odo_y = it.py; p_odo_yaw = y; p_odo_seen = 1;
            end
            return;
        end
        if (it.kind != KIND_TICK || !p_map_seen || !p_odo_seen) return;
        trig_q(p_map_yaw, c, s);
        ox = longint'($signed(p_off_x));
        oy = longint'($signed(p_off_y));
        w = 32'(longint'($signed(p_map_x)) + rnd_shift(c * ox - s * oy, FRACB));
        mbx = longint'($signed(w));
        w = 32'(longint'($signed(p_map_y)) + rnd_shift(s * ox + c * oy, FRACB));
        mby = longint'($signed(w));
        mb_yaw = p_map_yaw + p_off_yaw;
        trig_q(p_odo_yaw, c, s);
        ox = longint'($signed(p_odo_x));
        oy = longint'($signed(p_odo_y));
        w = 32'(rnd_shift(-(c * ox) - s * oy, FRACB));
        ix = longint'($signed(w));
        w = 32'(rnd_shift(s * ox - c * oy, FRACB));
        iy = longint'($signed(w));
        trig_q(mb_yaw, c, s);
        r.tx = 32'(mbx + rnd_shift(c * ix - s * iy, FRACB));
        r.ty = 32'(mby + rnd_shift(s * ix + c * iy, FRACB));
        yaw = mb_yaw - p_odo_yaw;
        t = (yaw == 16'h8000) ? 32768 : longint'($signed(yaw));
        tsum = t * 32768;
        cordic_sincos(32'(tsum), hw, hz);
        r.rz = 16'(clamp_unit(rnd_shift(hz, 16)));
        r.rw = 16'(clamp_unit(rnd_shift(hw, 16)));
        tol = (p_tol > 999999999) ? 999999999 : p_tol;
        ns = p_map_nsec + tol;
        carry = ns / 1000000000;
        ns -= carry * 1000000000;
        sec = p_map_sec + carry;
        if (sec > 2147483647) sec = 2147483647;
        r.sec = 31'(sec);
        r.nsec = 30'(ns);
        expected_corr.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 93) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // Driver.
    int send_gap = 0;
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 0;
        end else if (!in_valid || in_ready) begin
            if (in_valid) begin
                predict_correction(pending_items.pop_front());
                items_sent++;
            end
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                in_valid <= 0;
            end else if (pending_items.size() > 0) begin
                in_valid <= 1;
                in_kind <= pending_items[0].kind;
                in_px <= pending_items[0].px;
                in_py <= pending_items[0].py;
                in_qx <= pending_items[0].qx;
                in_qy <= pending_items[0].qy;
                in_qz <= pending_items[0].qz;
                in_qw <= pending_items[0].qw;
                in_sec <= pending_items[0].sec;
                in_nsec <= pending_items[0].nsec;
                send_gap <= gap_len();
            end else begin
                in_valid <= 0;
            end
        end
    end

    // Monitor and receiver stalls.
    int recv_gap = 0;
    always @(posedge clk) begin
        correction_t e;
        if (rst_n && out_valid && out_ready) begin
            results_seen++;
            if (expected_corr.size() == 0) begin
                report_mismatch("unexpected result", 0, 0);
            end else begin
                e = expected_corr.pop_front();
                if (out_tx !== e.tx) report_mismatch("trans_x", out_tx, $signed(e.tx));
                if (out_ty !== e.ty) report_mismatch("trans_y", out_ty, $signed(e.ty));
                if (out_rz !== e.rz) report_mismatch("rot_z", out_rz, $signed(e.rz));
                if (out_rw !== e.rw) report_mismatch("rot_w", out_rw, $signed(e.rw));
                if (out_sec !== e.sec) report_mismatch("out_sec", out_sec, e.sec);
                if (out_nsec !== e.nsec) report_mismatch("out_nsec", out_nsec, e.nsec);
            end
        end
        if (hold_req && !hold_done) begin
            out_ready <= 0;
            if (hold_cycles >= HOLD_CYCLES) begin
                hold_done <= 1;
            end else begin
                hold_cycles <= hold_cycles + 1;
            end
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            out_ready <= 0;
        end else begin
            out_ready <= 1;
            recv_gap <= gap_len();
        end
    end

    // Watchdog.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
            || (hold_req && !hold_done)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCH_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic add_item(input logic [1:0] k, input logic [31:0] x, input logic [31:0] y,
                            input logic [15:0] a, input logic [15:0] b, input logic [15:0] c,
                            input logic [15:0] d, input logic [30:0] s, input logic [29:0] n);
        pose_item_t it;
        it.kind = k; it.px = x; it.py = y;
        it.qx = a; it.qy = b; it.qz = c; it.qw = d;
        it.sec = s; it.nsec = n;
        pending_items.push_back(it);
    endtask

    function automatic logic [15:0] rand_q();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'($urandom);
        if (r == 1) return 16'($signed(16'($urandom_range(0, 2) * 16384 - 16384)));
        return 16'($urandom_range(0, 32768) - 16384);
    endfunction

    function automatic logic [31:0] rand_pos();
        if ($urandom_range(0, 3) == 0) return $urandom;
        return 32'($signed(32'($urandom_range(0, 2 ** 24) - 2 ** 23)));
    endfunction

    task automatic add_random(input int n);
        int r;
        logic [1:0] k;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 19);
            k = (r < 7) ? KIND_MAP : (r < 13) ? KIND_ODO : (r < 19) ? KIND_TICK : 2'd3;
            add_item(k, rand_pos(), rand_pos(), rand_q(), rand_q(), rand_q(), rand_q(),
                     ($urandom_range(0, 9) == 0) ? 31'(31'h7FFF_FFFF - $urandom_range(0, 2))
                                                 : 31'($urandom),
                     ($urandom_range(0, 4) == 0) ? 30'(999999999 - $urandom_range(0, 3))
                                                 : 30'($urandom_range(0, 999999999)));
        end
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || in_valid || expected_corr.size() > 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 0;
        case (idx)
            CFG_OFFSET_X:   p_off_x = val;
            CFG_OFFSET_Y:   p_off_y = val;
            CFG_OFFSET_YAW: p_off_yaw = val[15:0];
            CFG_TOLERANCE:  p_tol = {2'b0, val[29:0]};
        endcase
    endtask

    initial begin
        p_off_x = 17302; p_off_y = 1114; p_off_yaw = 16'h8000; p_tol = 20000000;
        p_map_x = 0; p_map_y = 0; p_odo_x = 0; p_odo_y = 0;
        p_map_sec = 0; p_map_nsec = 0; p_map_yaw = 0; p_odo_yaw = 0;
        p_map_seen = 0; p_odo_seen = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed part at reset configuration.
        add_item(KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 0);
        add_item(KIND_MAP, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 16384, 31'h7FFF_FFFF,
                 999999999);
        add_item(KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 0);
        add_item(KIND_ODO, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 16384, 0, 0, 0);
        add_item(KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 0);
        add_item(KIND_ODO, 0, 0, 0, 0, 0, 0, 0, 0);
        add_item(KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 0);
        add_item(2'd3, 32'hFFFF_FFFF, 1, 16'hFFFF, 16'h7FFF, 16'h8000, 1, 5, 5);
        add_item(KIND_MAP, 0, 0, 16'hC000, 16384, 16'hC000, 16384, 0, 0);
        add_item(KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 0);
        add_item(KIND_MAP, 65536, -65536, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 100, 0);
        add_item(KIND_ODO, 12345, 678, 0, 0, 11585, 11585, 0, 0);
        add_item(KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 0);
        wait_drained();

        write_reg(CFG_OFFSET_X, 32'h7FFF_FFFF);
        write_reg(CFG_OFFSET_Y, 32'h8000_0000);
        write_reg(CFG_OFFSET_YAW, 32'h0000_7FFF);
        write_reg(CFG_TOLERANCE, 999999999);
        add_random(300);
        // Long receiver stall while the sender keeps going.
        wait (items_sent > 100);
        hold_req = 1;
        wait (hold_done);
        hold_req = 0;
        wait_drained();

        write_reg(CFG_OFFSET_X, 0);
        write_reg(CFG_OFFSET_Y, 0);
        write_reg(CFG_OFFSET_YAW, 0);
        write_reg(CFG_TOLERANCE, 32'h3FFF_FFFF);
        add_random(450);
        wait_drained();

        write_reg(CFG_OFFSET_X, 32'h8000_0000);
        write_reg(CFG_OFFSET_Y, 32'h7FFF_FFFF);
        write_reg(CFG_OFFSET_YAW, 32'h0000_8000);
        write_reg(CFG_TOLERANCE, 0);
        add_random(450);
        wait_drained();

        write_reg(CFG_OFFSET_X, $urandom);
        write_reg(CFG_OFFSET_Y, $urandom);
        write_reg(CFG_OFFSET_YAW, $urandom);
        write_reg(CFG_TOLERANCE, $urandom_range(0, 999999999));
        add_random(640);
        wait_drained();

        $display("Sent %0d transactions over five register settings; %0d corrections checked.",
                 items_sent, results_seen);
        if (errors == 0 && expected_corr.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
